### design/swtl_pkg.sv
// Package for the segment waveform table lookup unit.
// Holds table sizes, operation and status codes, register indexes and the sequencer state type.
// No dependencies.
package swtl_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int NUM_WAVES    = 256;

    localparam int SEG_AW  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS) + 1;
    localparam int WAVE_AW = $clog2(NUM_WAVES);
    localparam int SEG_W   = 48;  // inclusive end (32) and discrete value (16)

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    localparam logic CFG_STEP_SIZE    = 1'b0;
    localparam logic CFG_VALUE_OFFSET = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_RD,
        S_APP_WR,
        S_MOD,
        S_SRCH_RD,
        S_SRCH_CK,
        S_MUL,
        S_SUB,
        S_DONE
    } t_state;

endpackage

### design/swtl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/segment_waveform_table_lookup_unit.sv
// Segment waveform table lookup unit: top level with sequencer and datapath.
// Depends on swtl_pkg and swtl_ram.
// Clear, unused mode and empty query go straight to the done state; append reads the
// per-wave count, then writes; a query runs a restoring modulo, one quotient bit a cycle,
// a table walk checking one entry at a time on the RAM port, then multiply and subtract.
// One item at a time: the input is ready again once the result is in the output register.
// Reset (synchronous, active low) empties the table and zeroes both config registers.
module segment_waveform_table_lookup_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_seg_length,
    input  logic signed [15:0] i_discrete_value,
    input  logic [7:0]  i_wave_number,
    input  logic [31:0] i_timestamp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_start_index,
    output logic [31:0] o_end_index,
    output logic [7:0]  o_index_in_wave,
    output logic [7:0]  o_slot,
    output logic signed [15:0] o_found_value,
    output logic signed [40:0] o_scaled_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import swtl_pkg::*;

    t_state r_state, n_state;

    logic [23:0] r_step;
    logic [31:0] r_offset;

    logic [CNT_W-1:0]  r_seg_count;
    logic [31:0]       r_last_end;
    logic [NUM_WAVES-1:0] r_pw_valid;

    logic [31:0] r_len;
    logic [15:0] r_dv;
    logic [WAVE_AW-1:0] r_wave;
    logic [31:0] r_ts;
    logic [32:0] r_rem;
    logic [4:0]  r_bit;
    logic [SEG_AW-1:0] r_idx;
    logic [31:0] r_prev_end;
    logic [15:0] r_found_val;
    logic signed [40:0] r_prod;

    logic [1:0]  r_res_status;
    logic [31:0] r_res_start, r_res_end;
    logic [7:0]  r_res_iw, r_res_slot;
    logic [15:0] r_res_val;
    logic [40:0] r_res_scaled;

    logic        r_out_valid;
    logic [1:0]  r_o_status;
    logic [31:0] r_o_start, r_o_end;
    logic [7:0]  r_o_iw, r_o_slot;
    logic [15:0] r_o_val;
    logic [40:0] r_o_scaled;

    // RAM controls
    logic              c_seg_we, c_pw_we;
    logic [SEG_AW-1:0] c_seg_raddr;
    logic [SEG_W-1:0]  w_seg_rdata;
    logic [CNT_W-1:0]  w_pw_rdata;
    logic [CNT_W-1:0]  w_pw_count;
    logic              c_accept, c_load_out, c_walk_on;

    logic [32:0] w_start, w_len, w_total, w_shift;
    logic [33:0] w_end;
    logic        w_full, w_ovf, w_ge;

    assign c_accept    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign w_start = (r_seg_count == '0) ? 33'd0 : {1'b0, r_last_end} + 33'd1;
    assign w_len   = (r_len == 32'd0) ? {1'b1, 32'd0} : {1'b0, r_len};
    assign w_end   = {1'b0, w_start} + {1'b0, w_len} - 34'd1;
    assign w_full  = r_seg_count >= CNT_W'(MAX_SEGMENTS);
    assign w_ovf   = |w_end[33:32];
    assign w_pw_count = r_pw_valid[r_wave] ? w_pw_rdata : '0;

    assign w_total = {1'b0, r_last_end} + 33'd1;
    assign w_shift = {r_rem[31:0], r_ts[31]};
    assign w_ge    = w_shift >= w_total;

    assign c_walk_on = ({1'b0, r_idx} + CNT_W'(1) < r_seg_count)
                       && (w_seg_rdata[47:16] < r_rem[31:0]);

    swtl_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (c_seg_we),
        .i_waddr (r_seg_count[SEG_AW-1:0]),
        .i_wdata ({w_end[31:0], r_dv}),
        .i_raddr (c_seg_raddr),
        .o_rdata (w_seg_rdata)
    );

    swtl_ram #(.WIDTH(CNT_W), .DEPTH(NUM_WAVES)) u_pw_ram (
        .i_clk   (i_clk),
        .i_we    (c_pw_we),
        .i_waddr (r_wave),
        .i_wdata (w_pw_count + CNT_W'(1)),
        .i_raddr (r_wave),
        .o_rdata (w_pw_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    if (i_mode == MODE_APPEND) begin
                        n_state = S_APP_RD;
                    end else if (i_mode == MODE_QUERY && r_seg_count != '0) begin
                        n_state = S_MOD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_APP_RD:  n_state = S_APP_WR;
            S_APP_WR:  n_state = S_DONE;
            S_MOD:     n_state = (r_bit == 5'd0) ? S_SRCH_RD : S_MOD;
            S_SRCH_RD: n_state = S_SRCH_CK;
            S_SRCH_CK: n_state = c_walk_on ? S_SRCH_RD : S_MUL;
            S_MUL:     n_state = S_SUB;
            S_SUB:     n_state = S_DONE;
            S_DONE:    n_state = c_load_out ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        c_seg_we    = (r_state == S_APP_WR) && !w_full && !w_ovf;
        c_pw_we     = c_seg_we;
        c_seg_raddr = r_idx;
        c_load_out  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_offset    <= '0;
            r_seg_count <= '0;
            r_last_end  <= '0;
            r_pw_valid  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_STEP_SIZE:    r_step   <= i_cfg_data[23:0];
                    CFG_VALUE_OFFSET: r_offset <= i_cfg_data;
                    default:          r_step   <= r_step;
                endcase
            end
            if (r_state == S_IDLE && c_accept && i_mode == MODE_CLEAR) begin
                r_seg_count <= '0;
                r_last_end  <= '0;
                r_pw_valid  <= '0;
            end
            if (c_seg_we) begin
                r_seg_count        <= r_seg_count + CNT_W'(1);
                r_last_end         <= w_end[31:0];
                r_pw_valid[r_wave] <= 1'b1;
            end
            if (c_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    r_len        <= i_seg_length;
                    r_dv         <= i_discrete_value;
                    r_wave       <= i_wave_number[WAVE_AW-1:0];
                    r_ts         <= i_timestamp;
                    r_rem        <= '0;
                    r_bit        <= 5'd31;
                    r_idx        <= '0;
                    r_prev_end   <= '0;
                    r_res_status <= (i_mode == MODE_QUERY && r_seg_count == '0)
                                    ? STAT_EMPTY : STAT_OK;
                    r_res_start  <= '0;
                    r_res_end    <= '0;
                    r_res_iw     <= '0;
                    r_res_slot   <= '0;
                    r_res_val    <= '0;
                    r_res_scaled <= '0;
                end
            end
            S_APP_WR: begin
                priority if (w_full) begin
                    r_res_status <= STAT_FULL;
                end else if (w_ovf) begin
                    r_res_status <= STAT_OVERFLOW;
                end else begin
                    r_res_start <= w_start[31:0];
                    r_res_end   <= w_end[31:0];
                    r_res_iw    <= w_pw_count[7:0];
                    r_res_slot  <= 8'(r_seg_count);
                end
            end
            S_MOD: begin
                // one restoring step of timestamp mod total length
                r_rem <= w_ge ? (w_shift - w_total) : w_shift;
                r_ts  <= {r_ts[30:0], 1'b0};
                r_bit <= r_bit - 5'd1;
            end
            S_SRCH_CK: begin
                if (c_walk_on) begin
                    r_prev_end <= w_seg_rdata[47:16] + 32'd1;
                    r_idx      <= r_idx + SEG_AW'(1);
                end else begin
                    r_found_val <= w_seg_rdata[15:0];
                    r_res_start <= r_prev_end;
                    r_res_end   <= w_seg_rdata[47:16];
                    r_res_slot  <= 8'(r_idx);
                    r_res_val   <= w_seg_rdata[15:0];
                end
            end
            S_MUL: begin
                // sign-extend the found value and zero-extend the step so the product keeps its full width
                r_prod <= 41'($signed(r_found_val)) * 41'($signed({1'b0, r_step}));
            end
            S_SUB: begin
                r_res_scaled <= r_prod - 41'($signed(r_offset));
            end
            default: ;
        endcase
        if (c_load_out) begin
            r_o_status <= r_res_status;
            r_o_start  <= r_res_start;
            r_o_end    <= r_res_end;
            r_o_iw     <= r_res_iw;
            r_o_slot   <= r_res_slot;
            r_o_val    <= r_res_val;
            r_o_scaled <= r_res_scaled;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_start_index   = r_o_start;
    assign o_end_index     = r_o_end;
    assign o_index_in_wave = r_o_iw;
    assign o_slot          = r_o_slot;
    assign o_found_value   = r_o_val;
    assign o_scaled_value  = r_o_scaled;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_count <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count beyond table size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_accept |=> !o_in_ready)
        else $error("ready while an item is in work");

    a_walk_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_CK) |-> ({1'b0, r_idx} < r_seg_count))
        else $error("table walk past last segment");

    a_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_RD) |-> (r_rem < w_total))
        else $error("wrapped timestamp not below total length");

    a_write_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_seg_we |=> (r_seg_count == $past(r_seg_count) + CNT_W'(1)))
        else $error("append did not advance segment count");
endmodule

### verif/tb_segment_waveform_table_lookup_unit.sv
// Testbench for segment_waveform_table_lookup_unit: random and directed clear, append, query and
// unused-mode items, checked against an in-bench table model. Depends on swtl_pkg and the DUT.
`timescale 1ns / 100ps

module tb_segment_waveform_table_lookup_unit;
    import swtl_pkg::*;

    localparam int LIMIT = 4_000_000;

    typedef struct {
        logic [1:0]         mode;
        logic [31:0]        seg_length;
        logic signed [15:0] discrete_value;
        logic [7:0]         wave_number;
        logic [31:0]        timestamp;
    } t_item;

    typedef struct {
        logic [1:0]         status;
        logic [31:0]        start_index;
        logic [31:0]        end_index;
        logic [7:0]         index_in_wave;
        logic [7:0]         slot;
        logic signed [15:0] found_value;
        logic signed [40:0] scaled_value;
    } t_lookup;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode = '0;
    logic [31:0] i_seg_length = '0;
    logic signed [15:0] i_discrete_value = '0;
    logic [7:0]  i_wave_number = '0;
    logic [31:0] i_timestamp = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_start_index;
    logic [31:0] o_end_index;
    logic [7:0]  o_index_in_wave;
    logic [7:0]  o_slot;
    logic signed [15:0] o_found_value;
    logic signed [40:0] o_scaled_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_STEP_SIZE;
    logic [31:0] i_cfg_data = '0;

    segment_waveform_table_lookup_unit DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_item   pending_items[$];
    t_lookup expected_lookups[$];
    int      cycle_count = 0;
    int      fail_count = 0;

    task automatic queue_item(input t_item it);
        pending_items = {pending_items, it};
    endtask

    // table shadow
    logic [31:0]        tbl_end[MAX_SEGMENTS];
    logic signed [15:0] tbl_value[MAX_SEGMENTS];
    logic [8:0]         wave_count[NUM_WAVES];
    int                 tbl_count = 0;
    logic [31:0]        tbl_last_end = '0;
    logic [23:0]        cur_step = '0;
    logic signed [31:0] cur_offset = '0;

    task automatic clear_shadow();
        foreach (wave_count[w]) wave_count[w] = '0;
        tbl_count = 0;
        tbl_last_end = '0;
    endtask

    task automatic predict_lookup(input t_item it);
        t_lookup     r;
        logic [32:0] len;
        logic [32:0] start;
        logic [32:0] stop;
        logic [32:0] total;
        logic [32:0] t;
        longint      prod;
        int          i;
        r = '{default: '0};
        case (it.mode)
            MODE_CLEAR: clear_shadow();
            MODE_APPEND: begin
                len = (it.seg_length == 0) ? 33'h1_0000_0000 : {1'b0, it.seg_length};
                start = (tbl_count == 0) ? 33'd0 : {1'b0, tbl_last_end} + 33'd1;
                stop = start + len - 33'd1;
                if (tbl_count >= MAX_SEGMENTS) begin
                    r.status = STAT_FULL;
                end else if (stop[32]) begin
                    r.status = STAT_OVERFLOW;
                end else begin
                    tbl_end[tbl_count] = stop[31:0];
                    tbl_value[tbl_count] = it.discrete_value;
                    r.status = STAT_OK;
                    r.start_index = start[31:0];
                    r.end_index = stop[31:0];
                    r.index_in_wave = wave_count[it.wave_number][7:0];
                    r.slot = tbl_count[7:0];
                    wave_count[it.wave_number] = wave_count[it.wave_number] + 9'd1;
                    tbl_count++;
                    tbl_last_end = stop[31:0];
                end
            end
            MODE_QUERY: begin
                if (tbl_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    total = {1'b0, tbl_last_end} + 33'd1;
                    t = {1'b0, it.timestamp} % total;
                    i = 0;
                    while (i + 1 < tbl_count && {1'b0, tbl_end[i]} < t) i++;
                    prod = longint'(tbl_value[i]) * longint'({1'b0, cur_step})
                           - longint'(cur_offset);
                    r.status = STAT_OK;
                    r.start_index = (i == 0) ? 32'd0 : tbl_end[i-1] + 32'd1;
                    r.end_index = tbl_end[i];
                    r.slot = i[7:0];
                    r.found_value = tbl_value[i];
                    r.scaled_value = prod[40:0];
                end
            end
            default: ;
        endcase
        expected_lookups = {expected_lookups, r};
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    endtask

    function automatic bit idle_now();
        // quiet window: no idling at all
        if (cycle_count % 60000 < 12000) return 1'b0;
        return $urandom_range(99) < 34;
    endfunction

    // item driver and predictor feed
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                predict_lookup('{i_mode, i_seg_length, i_discrete_value, i_wave_number,
                                 i_timestamp});
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() > 0 && !idle_now()) begin
                    t_item it;
                    it = pending_items.pop_front();
                    i_mode <= it.mode;
                    i_seg_length <= it.seg_length;
                    i_discrete_value <= it.discrete_value;
                    i_wave_number <= it.wave_number;
                    i_timestamp <= it.timestamp;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("** segment_waveform_table_lookup_unit: FAILED **");
            $finish;
        end
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_lookups.size() == 0) begin
                    report_mismatch("unexpected result status", o_status, 0);
                end else begin
                    t_lookup e;
                    e = expected_lookups.pop_front();
                    if (o_status !== e.status) report_mismatch("status", o_status, e.status);
                    if (o_start_index !== e.start_index)
                        report_mismatch("start_index", o_start_index, e.start_index);
                    if (o_end_index !== e.end_index)
                        report_mismatch("end_index", o_end_index, e.end_index);
                    if (o_index_in_wave !== e.index_in_wave)
                        report_mismatch("index_in_wave", o_index_in_wave, e.index_in_wave);
                    if (o_slot !== e.slot) report_mismatch("slot", o_slot, e.slot);
                    if (o_found_value !== e.found_value)
                        report_mismatch("found_value", o_found_value, e.found_value);
                    if (o_scaled_value !== e.scaled_value)
                        report_mismatch("scaled_value", o_scaled_value, e.scaled_value);
                end
            end
            i_out_ready <= !idle_now();
        end
    end

    function automatic t_item mk(input logic [1:0] mode, input logic [31:0] len,
                                 input logic [15:0] dv, input logic [7:0] wave,
                                 input logic [31:0] ts);
        t_item it;
        it.mode = mode;
        it.seg_length = len;
        it.discrete_value = dv;
        it.wave_number = wave;
        it.timestamp = ts;
        return it;
    endfunction

    function automatic logic [31:0] rand_len();
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return 32'd0;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 2000);
        endcase
    endfunction

    function automatic logic [31:0] rand_ts();
        return $urandom_range(1) ? $urandom() : $urandom_range(0, 20000);
    endfunction

    task automatic push_append();
        queue_item(mk(MODE_APPEND, rand_len(), 16'($urandom()), 8'($urandom()), $urandom()));
    endtask

    task automatic push_query();
        queue_item(mk(MODE_QUERY, $urandom(), 16'($urandom()), 8'($urandom()), rand_ts()));
    endtask

    // well-formed run: clear, appends with queries mixed in, a little noise
    task automatic push_run(input int appends);
        queue_item(mk(MODE_CLEAR, $urandom(), 16'($urandom()), 8'($urandom()), $urandom()));
        for (int k = 0; k < appends; k++) begin
            if ($urandom_range(9) == 0)
                queue_item(mk(MODE_UNUSED, $urandom(), 16'($urandom()), 8'($urandom()),
                              $urandom()));
            if ($urandom_range(2) == 0) push_query();
            push_append();
        end
        repeat ($urandom_range(2, 6)) push_query();
    endtask

    task automatic settle();
        while (pending_items.size() > 0 || i_in_valid || expected_lookups.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_STEP_SIZE) cur_step = data[23:0];
        else cur_offset = data;
        @(posedge i_clk);
    endtask

    initial begin
        int sent;
        logic [23:0] steps[5];
        logic [31:0] offsets[5];
        clear_shadow();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty query, zero length, overflow, extremes, unused mode
        queue_item(mk(MODE_QUERY, 0, 0, 0, 32'hFFFF_FFFF));
        queue_item(mk(MODE_APPEND, 32'd0, 16'sh7FFF, 8'hFF, 0));
        queue_item(mk(MODE_QUERY, 0, 0, 0, 32'hFFFF_FFFF));
        queue_item(mk(MODE_APPEND, 32'd1, 16'sh8000, 8'h00, 0));
        queue_item(mk(MODE_UNUSED, 32'hFFFF_FFFF, 16'shFFFF, 8'hFF, 32'hFFFF_FFFF));
        queue_item(mk(MODE_CLEAR, 0, 0, 0, 0));
        queue_item(mk(MODE_APPEND, 32'hFFFF_FFFF, 16'sh8000, 8'h00, 0));
        queue_item(mk(MODE_APPEND, 32'd1, 16'sh0001, 8'h00, 0));
        queue_item(mk(MODE_APPEND, 32'd2, 16'sh0001, 8'h00, 0));
        queue_item(mk(MODE_QUERY, 0, 0, 0, 32'hFFFF_FFFF));
        queue_item(mk(MODE_QUERY, 0, 0, 0, 32'hFFFF_FFFE));
        queue_item(mk(MODE_CLEAR, 0, 0, 0, 0));
        queue_item(mk(MODE_APPEND, 32'd5, 16'sh7FFF, 8'h07, 0));
        queue_item(mk(MODE_APPEND, 32'd3, 16'sh8000, 8'h07, 0));
        queue_item(mk(MODE_APPEND, 32'd4, 16'sh0000, 8'h80, 0));
        queue_item(mk(MODE_QUERY, 0, 0, 0, 32'd0));
        queue_item(mk(MODE_QUERY, 0, 0, 0, 32'd5));
        queue_item(mk(MODE_QUERY, 0, 0, 0, 32'd11));
        queue_item(mk(MODE_QUERY, 0, 0, 0, 32'd12));
        settle();

        steps = '{24'hFF_FFFF, 24'd0, 24'd1, 24'hFF_FFFF, 24'h00_0000};
        offsets = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0};
        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_STEP_SIZE, (p < 5) ? {8'h0, steps[p]} : $urandom());
            write_reg(CFG_VALUE_OFFSET, (p < 5) ? offsets[p] : $urandom());
            sent = 0;
            if (p == 2) begin
                // fill the table past its size, then look up
                queue_item(mk(MODE_CLEAR, 0, 0, 0, 0));
                for (int k = 0; k < MAX_SEGMENTS + 3; k++)
                    queue_item(mk(MODE_APPEND, $urandom_range(1, 16),
                                  16'($urandom()), 8'($urandom()), 0));
                repeat (8) push_query();
            end
            while (sent < 30) begin
                int n;
                n = $urandom_range(1, 12);
                push_run(n);
                sent += 2 * n + 4;
            end
            settle();
        end

        if (fail_count == 0)
            $display("** segment_waveform_table_lookup_unit: PASSED **");
        else
            $display("** segment_waveform_table_lookup_unit: FAILED **");
        $finish;
    end

endmodule

### segment_waveform_table_lookup_unit.f
design/swtl_pkg.sv
design/swtl_ram.sv
design/segment_waveform_table_lookup_unit.sv
verif/tb_segment_waveform_table_lookup_unit.sv
